// ----- src/i2a_pkg.sv -----
// Package for the integer to decimal text converter.
// Holds character codes, digit geometry and the controller state type.
// No dependencies.
package i2a_pkg;

	localparam int VALUE_W   = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W   = 4;
	localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
	localparam int CNT_W     = $clog2(VALUE_W);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

endpackage

// ----- src/int32_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per result.
// Uses i2a_pkg for character codes, digit geometry and the state type.
//
// Usage:
//   Raise start with a value while busy is low; the value is taken at that
//   edge and busy rises. The magnitude is shifted one bit per cycle into ten
//   BCD digits (shift-and-add-3). Then an optional '-' is sent,
//   then the ten BCD digits are scanned one per cycle from the top, leading
//   zeros dropped; the lowest digit is always sent, so zero gives "0".
//   Each character appears on ascii_char for one cycle with strobe high;
//   last marks the final character of the number.
//   Busy covers the conversion, the sign (negative only) and the scan of
//   all ten digit positions, so the scan length is fixed by the ten digit
//   positions; a new value is accepted only once the block is back in
//   idle.
//   The receiver cannot stall: every strobe is a transfer.
//   Reset (arst_n low) returns the block to idle and clears strobe.
module int32_to_decimal_ascii (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [i2a_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [7:0]                  ascii_char,
	output logic                        last
);
	import i2a_pkg::*;

	state_t               state_q, state_d;
	logic [VALUE_W-1:0]   mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic                 started_q;
	logic                 strobe_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic                 accept;
	logic [DIGIT_W-1:0]   top_digit;
	logic                 conv_done;
	logic                 scan_end;
	logic                 emit;
	logic                 emit_last;
	logic [7:0]           emit_char;

	assign accept    = start && (state_q == ST_IDLE);
	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign conv_done = (cnt_q == CNT_W'(VALUE_W - 1));
	assign scan_end  = (cnt_q == CNT_W'(NUM_DIGITS - 1));

	// Add 3 to every digit of 5 or more before the next shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = neg_q ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (scan_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Character selection.
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_char = CHAR_ZERO;
		case (state_q)
			ST_SIGN: begin
				emit      = 1'b1;
				emit_char = CHAR_MINUS;
			end
			ST_DIGITS: begin
				emit      = started_q || (top_digit != '0) || scan_end;
				emit_last = scan_end;
				emit_char = CHAR_ZERO + {4'd0, top_digit};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= emit_char;
		last_q <= emit_last;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q     <= value[VALUE_W-1];
					mag_q     <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
					bcd_q     <= '0;
					cnt_q     <= '0;
					started_q <= 1'b0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
				mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
				cnt_q <= conv_done ? '0 : cnt_q + CNT_W'(1);
			end
			ST_DIGITS: begin
				// Advance to the next digit; hold the started flag once set.
				bcd_q     <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				cnt_q     <= cnt_q + CNT_W'(1);
				started_q <= started_q || (top_digit != '0);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign ascii_char = char_q;
	assign last       = last_q;

endmodule

// ----- tb/int32_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the signed integer to decimal text converter.
// Predicts the character stream of each accepted value and checks it in order.
// Depends on i2a_pkg and int32_to_decimal_ascii.
module int32_to_decimal_ascii_test;
	import i2a_pkg::*;

	localparam logic [VALUE_W-1:0] RADIX = 10;
	localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
	localparam int RANDOM_ITEMS = 405;
	localparam int DRAIN_CYCLES = 50;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      busy;
	logic                      strobe;
	logic [7:0]                ascii_char;
	logic                      last;

	text_char_t expected_text[$];
	int         text_errors = 0;
	int         cycle_count = 0;

	int32_to_decimal_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last       (last)
	);

	always #1 clk = ~clk;

	// Queue the decimal text of v, sign first, leading zeros dropped.
	function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits[$];
		text_char_t         c;
		mag = v[VALUE_W-1] ? -v : v;
		do begin
			digits.push_front(4'(mag % RADIX));
			mag = mag / RADIX;
		end while (mag != 0);
		if (v[VALUE_W-1]) begin
			c.ch = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		foreach (digits[i]) begin
			c.ch = CHAR_ZERO + 8'(digits[i]);
			c.last = (i == digits.size() - 1);
			expected_text.push_back(c);
		end
	endfunction

	// Present one value after a random idle gap; return at the transfer edge.
	// With no gap, start stays high and the next value follows back to back.
	task automatic send_value(input logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		predict_text(v);
	endtask

	task automatic test_extremes();
		send_value(0);
		send_value(1);
		send_value(-1);
		send_value(9);
		send_value(-9);
		send_value(MAX_VALUE);
		send_value(MIN_VALUE);
		send_value(MIN_VALUE + 1);
		send_value(MAX_VALUE - 1);
	endtask

	// Hit one to nine digits: for each power of ten p up to 10**8, send p-1 and -p.
	task automatic test_decade_edges();
		int p;
		p = 1;
		for (int k = 1; k <= 8; k++) begin
			p = p * 10;
			send_value(p - 1);
			send_value(-p);
		end
	endtask

	task automatic test_random_values();
		int v;
		int p;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 3))
				0: begin
					v = $urandom;
				end
				1: begin
					v = $urandom >> $urandom_range(0, 31);
					if ($urandom_range(0, 1) != 0)
						v = -v;
				end
				2: begin
					p = 1;
					repeat ($urandom_range(0, 9)) p = p * 10;
					v = p + $urandom_range(0, 2) - 1;
					if ($urandom_range(0, 1) != 0)
						v = -v;
				end
				default: begin
					v = $urandom_range(0, 40) - 20;
				end
			endcase
			send_value(v);
		end
	endtask

	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual %h last %b",
					$time, ascii_char, last);
				text_errors++;
			end else begin
				want = expected_text.pop_front();
				if (ascii_char !== want.ch) begin
					$display("%0t: ascii_char mismatch: expected %h, actual %h",
						$time, want.ch, ascii_char);
					text_errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, want.last, last);
					text_errors++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_decade_edges();
		test_random_values();
		start <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		// catch any stray characters after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (text_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/i2a_pkg.sv
src/int32_to_decimal_ascii.sv
tb/int32_to_decimal_ascii_test.sv
